[sv/vbb_pkg.sv]
`timescale 1ns / 1ps
// vbb_pkg: shared widths, the box record and the per-axis scaling functions
// for the vertex bounding box block. No dependencies.
package vbb_pkg;

  // coordinate width and its extreme values
  localparam int COORD_BITS = 16;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // register and result widths
  localparam int SCALE_W  = 16;
  localparam int CENTER_W = 22;
  localparam int HALF_W   = 21;
  localparam int FRAC_SHIFT = 11;
  localparam int MIN_HALF   = 13;

  // product widths, wide enough for the full product and the output slice
  localparam int CPROD_W = (COORD_BITS + SCALE_W + 2 > CENTER_W + FRAC_SHIFT + 1) ?
                           COORD_BITS + SCALE_W + 2 : CENTER_W + FRAC_SHIFT + 1;
  localparam int HPROD_W = (COORD_BITS + SCALE_W > HALF_W + FRAC_SHIFT) ?
                           COORD_BITS + SCALE_W : HALF_W + FRAC_SHIFT;

  // box of one finished vertex set
  typedef struct packed {
    logic                          seen;
    logic signed [COORD_BITS-1:0]  lo_x;
    logic signed [COORD_BITS-1:0]  lo_y;
    logic signed [COORD_BITS-1:0]  lo_z;
    logic signed [COORD_BITS-1:0]  hi_x;
    logic signed [COORD_BITS-1:0]  hi_y;
    logic signed [COORD_BITS-1:0]  hi_z;
  } box_t;

  // floor((lo + hi) * scale / 2048), kept to the center width
  function automatic logic [CENTER_W-1:0] axis_center(
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi,
    input logic [SCALE_W-1:0]           scale
  );
    logic signed [CPROD_W-1:0] sum;
    logic signed [CPROD_W-1:0] scl;
    logic signed [CPROD_W-1:0] prod;
    sum  = CPROD_W'(lo) + CPROD_W'(hi);
    scl  = CPROD_W'({1'b0, scale});
    prod = sum * scl;
    prod = prod >>> FRAC_SHIFT;
    return prod[CENTER_W-1:0];
  endfunction

  // floor((hi - lo) * scale / 2048), raised to the minimum half extent
  function automatic logic [HALF_W-1:0] axis_half(
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi,
    input logic [SCALE_W-1:0]           scale
  );
    logic signed [HPROD_W-1:0] diff;
    logic [HPROD_W-1:0]        prod;
    diff = HPROD_W'(hi) - HPROD_W'(lo);
    prod = HPROD_W'(unsigned'(diff)) * HPROD_W'(scale);
    prod = prod >> FRAC_SHIFT;
    if (prod < HPROD_W'(MIN_HALF)) begin
      prod = HPROD_W'(MIN_HALF);
    end
    return prod[HALF_W-1:0];
  endfunction

endpackage

[sv/vbb_in_if.sv]
`timescale 1ns / 1ps
// vbb_in_if: input channel of the bounding box block, one vertex per item.
// Depends on vbb_pkg.
interface vbb_in_if import vbb_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         has_vertex;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic                         last;

  modport source (output valid, has_vertex, vertex_x, vertex_y, vertex_z, last,
                  input ready);
  modport sink   (input valid, has_vertex, vertex_x, vertex_y, vertex_z, last,
                  output ready);
endinterface

[sv/vbb_out_if.sv]
`timescale 1ns / 1ps
// vbb_out_if: result channel of the bounding box block, one box per item.
// Depends on vbb_pkg.
interface vbb_out_if import vbb_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic signed [CENTER_W-1:0] center_z;
  logic [HALF_W-1:0]          half_x;
  logic [HALF_W-1:0]          half_y;
  logic [HALF_W-1:0]          half_z;

  modport source (output valid, found, center_x, center_y, center_z,
                  half_x, half_y, half_z, input ready);
  modport sink   (input valid, found, center_x, center_y, center_z,
                  half_x, half_y, half_z, output ready);
endinterface

[sv/vbb_accum.sv]
`timescale 1ns / 1ps
// vbb_accum: running per-axis min/max and the registered box of a finished set.
// Depends on vbb_pkg and vbb_in_if.
module vbb_accum import vbb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  vbb_in_if.sink    in_ch,
  output logic      box_valid,
  output box_t      box,
  input  logic      box_ready
);

  logic signed [COORD_BITS-1:0] lo_x, lo_y, lo_z;
  logic signed [COORD_BITS-1:0] hi_x, hi_y, hi_z;
  logic                         seen;
  logic                         accept;
  box_t                         merged;

  // take a new item whenever the box register is free or draining
  assign in_ch.ready = !box_valid || box_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // fold the incoming vertex into the running box
  always_comb begin
    merged.seen = seen;
    merged.lo_x = lo_x;
    merged.lo_y = lo_y;
    merged.lo_z = lo_z;
    merged.hi_x = hi_x;
    merged.hi_y = hi_y;
    merged.hi_z = hi_z;
    if (in_ch.has_vertex) begin
      merged.seen = 1'b1;
      if (in_ch.vertex_x < lo_x) merged.lo_x = in_ch.vertex_x;
      if (in_ch.vertex_y < lo_y) merged.lo_y = in_ch.vertex_y;
      if (in_ch.vertex_z < lo_z) merged.lo_z = in_ch.vertex_z;
      if (in_ch.vertex_x > hi_x) merged.hi_x = in_ch.vertex_x;
      if (in_ch.vertex_y > hi_y) merged.hi_y = in_ch.vertex_y;
      if (in_ch.vertex_z > hi_z) merged.hi_z = in_ch.vertex_z;
    end
  end

  // running state, cleared after the last item of a set
  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.last)) begin
      lo_x <= COORD_MAX;
      lo_y <= COORD_MAX;
      lo_z <= COORD_MAX;
      hi_x <= COORD_MIN;
      hi_y <= COORD_MIN;
      hi_z <= COORD_MIN;
      seen <= 1'b0;
    end else if (accept) begin
      lo_x <= merged.lo_x;
      lo_y <= merged.lo_y;
      lo_z <= merged.lo_z;
      hi_x <= merged.hi_x;
      hi_y <= merged.hi_y;
      hi_z <= merged.hi_z;
      seen <= merged.seen;
    end
  end

  // box register handshake: load on a last item, hold while not drained
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else begin
      box_valid <= (accept && in_ch.last) || (box_valid && !box_ready);
    end
  end

  // box payload
  always_ff @(posedge clk) begin
    if (accept && in_ch.last) begin
      box <= merged;
    end
  end

endmodule

[sv/vbb_scale.sv]
`timescale 1ns / 1ps
// vbb_scale: scales a finished box into center and half extents and holds
// the result register. Depends on vbb_pkg and vbb_out_if.
module vbb_scale import vbb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               box_valid,
  input  box_t               box,
  output logic               box_ready,
  input  logic [SCALE_W-1:0] scale_q,
  vbb_out_if.source          out_ch
);

  logic                       valid;
  logic                       found;
  logic [CENTER_W-1:0]        center_x, center_y, center_z;
  logic [HALF_W-1:0]          half_x, half_y, half_z;
  logic                       found_next;
  logic                       load;

  assign box_ready  = !valid || out_ch.ready;
  assign load       = box_valid && box_ready;
  assign found_next = box.seen && (scale_q != '0);

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (box_ready) begin
      valid <= box_valid;
    end
  end

  // result payload, zero when nothing was found
  always_ff @(posedge clk) begin
    if (load) begin
      found <= found_next;
      if (found_next) begin
        center_x <= axis_center(box.lo_x, box.hi_x, scale_q);
        center_y <= axis_center(box.lo_y, box.hi_y, scale_q);
        center_z <= axis_center(box.lo_z, box.hi_z, scale_q);
        half_x   <= axis_half(box.lo_x, box.hi_x, scale_q);
        half_y   <= axis_half(box.lo_y, box.hi_y, scale_q);
        half_z   <= axis_half(box.lo_z, box.hi_z, scale_q);
      end else begin
        center_x <= '0;
        center_y <= '0;
        center_z <= '0;
        half_x   <= '0;
        half_y   <= '0;
        half_z   <= '0;
      end
    end
  end

  assign out_ch.valid    = valid;
  assign out_ch.found    = found;
  assign out_ch.center_x = signed'(center_x);
  assign out_ch.center_y = signed'(center_y);
  assign out_ch.center_z = signed'(center_z);
  assign out_ch.half_x   = half_x;
  assign out_ch.half_y   = half_y;
  assign out_ch.half_z   = half_z;

endmodule

[sv/vertex_bounding_box.sv]
`timescale 1ns / 1ps
// vertex_bounding_box: axis-aligned bounding box of a vertex stream.
// Depends on vbb_pkg, vbb_in_if, vbb_out_if, vbb_accum and vbb_scale.
//
// Usage:
//   in_ch carries one vertex per item (has_vertex, vertex_x/y/z, last).
//   Items with has_vertex widen the running per-axis min/max. The item with
//   last set closes the set and yields one item on out_ch: found, the box
//   center and half extents, each scaled by scale_q / 2048 with floor
//   rounding; half extents are at least 13. Other items yield nothing. An empty
//   set, or scale_q of zero, gives found = 0, all fields zero. The user writes
//   scale_q via cfg_wr_en/cfg_wr_data only while the block is idle; unchecked.
// Timing:
//   One item per cycle while out_ch is not stalled. A result goes from its
//   last item through the box register, then through the per-axis
//   multipliers into the result register.
// Reset and stall:
//   rst (synchronous) clears the running box, drops both valid flags and
//   sets scale_q to 0.125 (256). When out_ch stalls, the result and box
//   registers hold and in_ch.ready falls once the box register is full.
module vertex_bounding_box import vbb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  vbb_in_if.sink             in_ch,
  vbb_out_if.source          out_ch
);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  logic [SCALE_W-1:0] scale_q;
  logic               box_valid;
  logic               box_ready;
  box_t               box;

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_q <= cfg_wr_data;
    end
  end

  vbb_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .box_valid (box_valid),
    .box       (box),
    .box_ready (box_ready)
  );

  vbb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .box_valid (box_valid),
    .box       (box),
    .box_ready (box_ready),
    .scale_q   (scale_q),
    .out_ch    (out_ch)
  );

endmodule
